/* rtl/bdqd_pkg.sv */
// Shared types and codes for the bounded deque with delete-by-value.
// Used by bdqd_ctrl, bdqd_dpath and bounded_deque_with_delete.
`timescale 1ns / 1ps

package bdqd_pkg;

   // Fixed field widths of the item channels
   localparam int OPCODE_W    = 3;
   localparam int VALUE_W     = 32;
   localparam int POPPED_W    = 32;
   localparam int OCC_W       = 5;
   localparam int STATUS_W    = 2;
   localparam int RSP_TDATA_W = 40;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DELETE     = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd3;

   // Commands from controller to datapath
   typedef struct packed {
      logic                load_item;
      logic                push_back;
      logic                push_front;
      logic                pop_back;
      logic                pop_front;
      logic                capture_pop;
      logic                scan_start;
      logic                scan_next;
      logic                move_read;
      logic                move_write;
      logic                shrink;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                emit;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                empty;
      logic                full;
      logic                match;
      logic                more;
      logic                out_busy;
   } sts_type;

endpackage

/* rtl/bdqd_dpath.sv */
// Datapath of the deque: entry memory, front/count pointers, scan index,
// latched item and the result output register. Uses bdqd_pkg.
`timescale 1ns / 1ps

module bdqd_dpath #(
   parameter int CAPACITY   = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bdqd_pkg::cmd_type                    cmd,
   output bdqd_pkg::sts_type                    sts,
   input  logic [bdqd_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [bdqd_pkg::VALUE_W-1:0]         req_value,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [bdqd_pkg::POPPED_W-1:0]        rsp_popped,
   output logic [bdqd_pkg::OCC_W-1:0]           rsp_occupancy,
   output logic [bdqd_pkg::STATUS_W-1:0]        rsp_status
);
   import bdqd_pkg::*;

   localparam int PW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // Entry memory and registered read data
   logic [WORD_WIDTH-1:0] entry_mem_ff [CAPACITY];
   logic [WORD_WIDTH-1:0] rd_data_ff;

   logic [PW-1:0]         front_ff, front_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [OPCODE_W-1:0]   op_ff;
   logic [WORD_WIDTH-1:0] word_ff;
   logic [STATUS_W-1:0]   res_status_ff;
   logic [POPPED_W-1:0]   res_popped_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POPPED_W-1:0]   rsp_popped_ff;
   logic [OCC_W-1:0]      rsp_occ_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;

   logic [WORD_WIDTH-1:0] word_in;
   logic [POPPED_W-1:0]   popped_in;
   logic [OCC_W-1:0]      occ_in;
   logic [CW-1:0]         count_m1;
   logic [CW-1:0]         idx_p1;
   logic [PW-1:0]         front_inc;
   logic [PW-1:0]         front_dec;
   logic                  wr_en;
   logic [PW-1:0]         wr_addr;
   logic [WORD_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [PW-1:0]         rd_addr;
   logic [CW-1:0]         wr_off;
   logic [CW-1:0]         rd_off;

   // Physical slot of an offset from the front, wrapped once
   function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] front,
                                             input logic [CW-1:0] offset);
      logic [CW:0] sum;
      sum = {{(CW + 1 - PW){1'b0}}, front} + {1'b0, offset};
      if (sum >= (CW + 1)'(CAPACITY)) begin
         sum = sum - (CW + 1)'(CAPACITY);
      end
      return sum[PW-1:0];
   endfunction

   // Size the input value to the stored word, and a stored word to the result
   logic [63+POPPED_W:0]           value_ext;
   logic [WORD_WIDTH+POPPED_W-1:0] rd_ext;
   logic [CW+OCC_W-1:0]            count_ext;
   assign value_ext = {{(64 + POPPED_W - VALUE_W){1'b0}}, req_value};
   assign word_in   = value_ext[WORD_WIDTH-1:0];
   assign rd_ext    = {{POPPED_W{1'b0}}, rd_data_ff};
   assign popped_in = rd_ext[POPPED_W-1:0];
   assign count_ext = {{OCC_W{1'b0}}, count_ff};
   assign occ_in    = count_ext[OCC_W-1:0];

   // Pointer arithmetic
   assign count_m1  = count_ff - CW'(1);
   assign idx_p1    = idx_ff + CW'(1);
   assign front_inc = (front_ff == PW'(CAPACITY - 1)) ? '0 : front_ff + PW'(1);
   assign front_dec = (front_ff == '0) ? PW'(CAPACITY - 1) : front_ff - PW'(1);

   // Select the memory port addresses
   always_comb begin
      wr_off  = cmd.move_write ? idx_ff : count_ff;
      rd_off  = cmd.pop_back ? count_m1 : idx_p1;
      wr_en   = cmd.push_back | cmd.push_front | cmd.move_write;
      wr_addr = cmd.push_front ? front_dec : slot_of(front_ff, wr_off);
      wr_data = cmd.move_write ? rd_data_ff : word_ff;
      rd_en   = cmd.pop_back | cmd.pop_front | cmd.scan_start | cmd.scan_next |
                cmd.move_read;
      rd_addr = (cmd.pop_front | cmd.scan_start) ? front_ff : slot_of(front_ff, rd_off);
   end

   // Next pointer state
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      if (cmd.push_back) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.push_front) begin
         front_in = front_dec;
         count_in = count_ff + CW'(1);
      end
      if (cmd.pop_back | cmd.shrink) begin
         count_in = count_m1;
      end
      if (cmd.pop_front) begin
         front_in = front_inc;
         count_in = count_m1;
      end
      if (cmd.scan_start) begin
         idx_in = '0;
      end
      if (cmd.scan_next | cmd.move_write) begin
         idx_in = idx_p1;
      end
   end

   // Hold pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
   end

   // Entry memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   // Latch the item and build its result
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff         <= req_opcode;
         word_ff       <= word_in;
         res_status_ff <= ST_OK;
         res_popped_ff <= '0;
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status_code;
      end
      if (cmd.capture_pop) begin
         res_popped_ff <= popped_in;
      end
   end

   // Output register: load on emit, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.emit) begin
         rsp_popped_ff <= res_popped_ff;
         rsp_occ_ff    <= occ_in;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_popped    = rsp_popped_ff;
   assign rsp_occupancy = rsp_occ_ff;
   assign rsp_status    = rsp_status_ff;

   // Status toward the controller
   always_comb begin
      sts.opcode   = op_ff;
      sts.empty    = (count_ff == '0);
      sts.full     = (count_ff == CW'(CAPACITY));
      sts.match    = (rd_data_ff == word_ff);
      sts.more     = (idx_p1 < count_ff);
      sts.out_busy = rsp_valid_ff & ~rsp_tready;
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff <= PW'(CAPACITY - 1))
      else $error("front index out of range");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_back || cmd.push_front) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("push did not grow the count");

endmodule

/* rtl/bdqd_ctrl.sv */
// Controller state machine of the deque: sequences push, pop, search and
// compaction steps and issues commands to bdqd_dpath. Uses bdqd_pkg.
`timescale 1ns / 1ps

module bdqd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  bdqd_pkg::sts_type sts,
   output bdqd_pkg::cmd_type cmd
);
   import bdqd_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_EXEC     = 3'd1;
   localparam logic [2:0] S_POP_WAIT = 3'd2;
   localparam logic [2:0] S_SCAN     = 3'd3;
   localparam logic [2:0] S_MOVE_RD  = 3'd4;
   localparam logic [2:0] S_MOVE_WR  = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FINISH;
            unique case (sts.opcode)
               OP_PUSH_BACK, OP_PUSH_FRONT: begin
                  if (sts.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_FULL;
                  end else if (sts.opcode == OP_PUSH_BACK) begin
                     cmd.push_back = 1'b1;
                  end else begin
                     cmd.push_front = 1'b1;
                  end
               end
               OP_POP_BACK, OP_POP_FRONT: begin
                  if (sts.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_EMPTY;
                  end else begin
                     cmd.pop_back  = (sts.opcode == OP_POP_BACK);
                     cmd.pop_front = (sts.opcode == OP_POP_FRONT);
                     state_in      = S_POP_WAIT;
                  end
               end
               OP_DELETE: begin
                  if (sts.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_NO_MATCH;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         S_POP_WAIT: begin
            cmd.capture_pop = 1'b1;
            state_in        = S_FINISH;
         end
         S_SCAN: begin
            priority if (sts.match) begin
               state_in = S_MOVE_RD;
            end else if (sts.more) begin
               cmd.scan_next = 1'b1;
            end else begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_NO_MATCH;
               state_in        = S_FINISH;
            end
         end
         S_MOVE_RD: begin
            if (sts.more) begin
               cmd.move_read = 1'b1;
               state_in      = S_MOVE_WR;
            end else begin
               cmd.shrink = 1'b1;
               state_in   = S_FINISH;
            end
         end
         S_MOVE_WR: begin
            cmd.move_write = 1'b1;
            state_in       = S_MOVE_RD;
         end
         S_FINISH: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Checks
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !sts.out_busy)
      else $error("result emitted over a waiting result");

   a_load_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load_item |=> state_ff == S_EXEC)
      else $error("accepted item not executed next");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.push_back, cmd.push_front, cmd.pop_back, cmd.pop_front,
                cmd.scan_start, cmd.scan_next, cmd.move_read, cmd.move_write}))
      else $error("more than one memory command in a cycle");

endmodule

/* rtl/bounded_deque_with_delete.sv */
// Bounded double-ended queue with delete-by-value, top level.
// Joins bdqd_ctrl and bdqd_dpath; uses bdqd_pkg.
`timescale 1ns / 1ps

// One item is worked at a time and gives exactly one result. After acceptance
// the item executes and the result register loads from the finish state; a
// push, a dropped push, an empty pop, a delete on an empty queue or an unused
// opcode go there straight from execution, while a pop first passes a wait
// state, as the entry memory has a registered read port. A delete compares
// entries from the front, one a cycle, up to the occupancy; on a match it
// shifts each later entry down to close the gap (a read and a write each, over
// the single memory port pair), else it finishes after the last compare.
// The block returns to idle as the result register loads, so the next item is
// accepted in the following cycle at the earliest.
// A new item is taken once the previous one has reached the output register,
// even while that result still waits; its own result is held back until the
// waiting one is taken.
// No clearing pass is needed after reset: only occupied entries are read.
module bounded_deque_with_delete #(
   parameter int CAPACITY   = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bdqd_pkg::VALUE_W-1:0]         req_tdata,   // [31:0] value
   input  logic [bdqd_pkg::OPCODE_W-1:0]        req_tuser,   // [2:0] opcode
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bdqd_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // [31:0] popped_word,
                                                             // [36:32] occupancy, zero pad
   output logic [bdqd_pkg::STATUS_W-1:0]        rsp_tuser    // [1:0] status
);
   import bdqd_pkg::*;

   cmd_type             cmd;
   sts_type             sts;
   logic [POPPED_W-1:0] rsp_popped;
   logic [OCC_W-1:0]    rsp_occupancy;

   bdqd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bdqd_dpath #(
      .CAPACITY   (CAPACITY),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_opcode    (req_tuser),
      .req_value     (req_tdata),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_popped    (rsp_popped),
      .rsp_occupancy (rsp_occupancy),
      .rsp_status    (rsp_tuser)
   );

   // Pack the result fields
   assign rsp_tdata = {{(RSP_TDATA_W - POPPED_W - OCC_W){1'b0}}, rsp_occupancy, rsp_popped};

endmodule

/* bench/tb_bounded_deque_with_delete.sv */
// Self-checking bench for the bounded deque with delete-by-value.
// Drives the req_/rsp_ streams of bounded_deque_with_delete and checks
// every result against a scoreboard; depends on bdqd_pkg.
`timescale 1ns / 1ps

module tb_bounded_deque_with_delete;
   import bdqd_pkg::*;

   localparam int DEPTH       = 16;
   localparam int SLOT_W      = $clog2(DEPTH);
   localparam int PHASE_ITEMS = 620;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 60;

   // Opcodes with no function: the block answers them without a change
   localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [POPPED_W-1:0] popped;
      logic [OCC_W-1:0]    occupancy;
      logic [STATUS_W-1:0] status;
   } deque_result_type;

   // Mirror of the deque contents; predicts one result per accepted item
   class deque_scoreboard_type;
      logic [VALUE_W-1:0] words [DEPTH];
      int unsigned        front_pos;
      int unsigned        held;
      int unsigned        errors;
      deque_result_type   results_due [$];

      function new();
         front_pos = 0;
         held      = 0;
         errors    = 0;
      endfunction

      function int unsigned pending();
         return results_due.size();
      endfunction

      function logic [SLOT_W-1:0] slot_of(input int unsigned offset);
         return SLOT_W'((front_pos + offset) % DEPTH);
      endfunction

      // Apply one accepted item to the mirror and queue its result
      function void note_request(input logic [OPCODE_W-1:0] op,
                                 input logic [VALUE_W-1:0] value);
         deque_result_type r;
         int unsigned      i;
         int unsigned      hit;
         bit               found;
         r.popped = '0;
         r.status = ST_OK;
         case (op)
            OP_PUSH_BACK: begin
               if (held >= DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  words[slot_of(held)] = value;
                  held++;
               end
            end
            OP_POP_BACK: begin
               if (held == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  held--;
                  r.popped = words[slot_of(held)];
               end
            end
            OP_PUSH_FRONT: begin
               if (held >= DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  front_pos = (front_pos + DEPTH - 1) % DEPTH;
                  words[SLOT_W'(front_pos)] = value;
                  held++;
               end
            end
            OP_POP_FRONT: begin
               if (held == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.popped = words[SLOT_W'(front_pos)];
                  front_pos = (front_pos + 1) % DEPTH;
                  held--;
               end
            end
            OP_DELETE: begin
               found = 1'b0;
               hit   = 0;
               for (i = 0; i < held; i++) begin
                  if (!found && words[slot_of(i)] == value) begin
                     found = 1'b1;
                     hit   = i;
                  end
               end
               if (!found) begin
                  r.status = ST_NO_MATCH;
               end else begin
                  // close the gap, keeping order
                  for (i = hit; i + 1 < held; i++)
                     words[slot_of(i)] = words[slot_of(i + 1)];
                  held--;
               end
            end
            default: ;
         endcase
         r.occupancy = held[OCC_W-1:0];
         results_due.push_back(r);
      endfunction

      // Compare one accepted result with the oldest prediction
      function void check_response(input logic [RSP_TDATA_W-1:0] data,
                                   input logic [STATUS_W-1:0] status);
         deque_result_type r;
         if (results_due.size() == 0) begin
            $display("%0t: unexpected result data=%h status=%0d", $realtime, data, status);
            errors++;
            return;
         end
         r = results_due.pop_front();
         if (data[POPPED_W-1:0] !== r.popped) begin
            $display("%0t: popped_word expected %h actual %h",
                     $realtime, r.popped, data[POPPED_W-1:0]);
            errors++;
         end
         if (data[POPPED_W+OCC_W-1:POPPED_W] !== r.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d",
                     $realtime, r.occupancy, data[POPPED_W+OCC_W-1:POPPED_W]);
            errors++;
         end
         if (status !== r.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, r.status, status);
            errors++;
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [VALUE_W-1:0]     req_tdata  = '0;    // [31:0] value
   logic [OPCODE_W-1:0]    req_tuser  = '0;    // [2:0] opcode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;          // [31:0] popped_word, [36:32] occupancy
   logic [STATUS_W-1:0]    rsp_tuser;          // [1:0] status

   deque_scoreboard_type board;
   int unsigned        send_idle_pct = 35;
   int unsigned        recv_idle_pct = 50;
   int unsigned        push_pct      = 45;
   logic               hold_toggle   = 1'b0;
   logic               hold_seen     = 1'b0;
   int unsigned        hold_left     = 0;
   logic [VALUE_W-1:0] value_pool [6];

   bounded_deque_with_delete dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL bounded_deque_with_delete");
      $finish;
   end

   // Check results; hold off for a long stretch when the sender asks
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata, rsp_tuser);
      if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one item, idling first at random, and wait for its acceptance
   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_request(op, value);
   endtask

   // Stop offering and wait until every result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   // Pick a word, mostly from a small pool so that deletes find matches
   function automatic logic [VALUE_W-1:0] pick_value();
      if ($urandom_range(99) < 70)
         return value_pool[3'($urandom_range(5))];
      return $urandom;
   endfunction

   task automatic send_random_item();
      int unsigned        r;
      logic [OPCODE_W-1:0] op;
      r = $urandom_range(99);
      if (r < 2)
         op = OPCODE_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      else if (r < 2 + push_pct)
         op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else if (r < 85)
         op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
      else
         op = OP_DELETE;
      send_item(op, pick_value());
   endtask

   // Empty cases, spare opcodes, a fill to full, then deletes and pops
   task automatic run_directed();
      logic [OPCODE_W-1:0] op;
      logic [VALUE_W-1:0]  value;
      int unsigned         i;
      send_item(OP_POP_BACK, 32'h0000_0000);
      send_item(OP_POP_FRONT, 32'hFFFF_FFFF);
      send_item(OP_DELETE, 32'h0000_0000);
      for (op = OP_SPARE_FIRST; op != OP_SPARE_LAST; op++)
         send_item(op, 32'hFFFF_FFFF);
      send_item(OP_SPARE_LAST, 32'hA5A5_5A5A);
      for (i = 0; i < DEPTH; i++) begin
         case (i)
            0: value = 32'h0000_0000;
            1: value = 32'hFFFF_FFFF;
            2, 9: value = 32'h8000_0000;
            3: value = 32'h7FFF_FFFF;
            default: value = $urandom;
         endcase
         send_item((i % 2 == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT, value);
      end
      send_item(OP_PUSH_BACK, 32'h1234_5678);
      send_item(OP_PUSH_FRONT, 32'h8765_4321);
      send_item(OP_DELETE, 32'h8000_0000);
      send_item(OP_DELETE, 32'h7FFF_FFFF);
      send_item(OP_DELETE, 32'h7FFF_FFFF);
      send_item(OP_POP_FRONT, 32'h0000_0000);
      send_item(OP_POP_BACK, 32'h0000_0000);
   endtask

   initial begin
      int unsigned phase;
      int unsigned n;
      board = new;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      wait_drained();

      for (phase = 0; phase < 3; phase++) begin
         // idle both sides, then swapped, then neither
         case (phase)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct = 50;
            end
            1: begin
               send_idle_pct = 50;
               recv_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         value_pool[0] = 32'h0000_0000;
         value_pool[1] = 32'hFFFF_FFFF;
         value_pool[2] = 32'h8000_0000;
         value_pool[3] = 32'h7FFF_FFFF;
         value_pool[4] = $urandom;
         value_pool[5] = $urandom;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // swing between filling and draining so both ends are reached
            if (n % 50 == 0)
               push_pct = $urandom_range(65, 20);
            if (n == 200 || (phase == 2 && n == 400))
               hold_toggle <= ~hold_toggle;
            send_random_item();
         end
         wait_drained();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("PASS bounded_deque_with_delete");
      else
         $display("FAIL bounded_deque_with_delete");
      $finish;
   end

endmodule
